>>> hdl/mrsp_pkg.sv
// Shared types and constants for the modem response and SMS parser.
// Depends on nothing; every other file in hdl/ refers to it by scoped names.
package mrsp_pkg;

	// Response event codes reported with each word.
	typedef enum logic [1:0] {
		EV_NONE   = 2'd0,
		EV_OK     = 2'd1,
		EV_PROMPT = 2'd2,
		EV_UNREAD = 2'd3
	} event_t;

	// Status handed from the reply recognizer to the text capture.
	typedef struct packed {
		logic last_unread;  // last complete reply before this byte was UNREAD
		logic unread_seen;  // this byte completes the UNREAD reply
	} reply_stat_t;

	// Character codes.
	localparam logic [7:0] CH_AT    = 8'h40;
	localparam logic [7:0] CH_O     = 8'h4F;
	localparam logic [7:0] CH_K     = 8'h4B;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_U     = 8'h55;
	localparam logic [7:0] CH_N     = 8'h4E;
	localparam logic [7:0] CH_R     = 8'h52;
	localparam logic [7:0] CH_E     = 8'h45;
	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] CH_D     = 8'h44;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_DIG0  = 8'h30;
	localparam logic [7:0] CH_DIG9  = 8'h39;

endpackage

>>> hdl/mrsp_reply.sv
// Reply recognizer: finds OK CR LF, the send prompt and UNREAD, and keeps the last reply.
// Depends on mrsp_pkg.
module mrsp_reply (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic [7:0]           rx_byte,
	output mrsp_pkg::event_t     resp_event,
	output logic                 done,
	output mrsp_pkg::reply_stat_t stat
);

	typedef enum logic [3:0] {
		RS_IDLE   = 4'd0,
		RS_O      = 4'd1,
		RS_GT     = 4'd2,
		RS_OK     = 4'd3,
		RS_OKCR   = 4'd4,
		RS_U      = 4'd5,
		RS_UN     = 4'd6,
		RS_UNR    = 4'd7,
		RS_UNRE   = 4'd8,
		RS_UNREA  = 4'd9
	} rstate_t;

	rstate_t          state_q, state_d;
	mrsp_pkg::event_t last_q, last_d;

	// Next state, event and completion pulse for the current byte.
	always_comb begin
		state_d    = RS_IDLE;
		last_d     = last_q;
		resp_event = mrsp_pkg::EV_NONE;
		done       = 1'b0;
		case (state_q)
			RS_IDLE: begin
				if (rx_byte == mrsp_pkg::CH_O) state_d = RS_O;
				else if (rx_byte == mrsp_pkg::CH_GT) state_d = RS_GT;
				else if (rx_byte == mrsp_pkg::CH_U) state_d = RS_U;
			end
			RS_O: if (rx_byte == mrsp_pkg::CH_K) state_d = RS_OK;
			RS_GT: begin
				if (rx_byte == mrsp_pkg::CH_SPACE) begin
					resp_event = mrsp_pkg::EV_PROMPT;
					last_d     = mrsp_pkg::EV_PROMPT;
				end
			end
			RS_OK: if (rx_byte == mrsp_pkg::CH_CR) state_d = RS_OKCR;
			RS_OKCR: begin
				if (rx_byte == mrsp_pkg::CH_LF) begin
					resp_event = mrsp_pkg::EV_OK;
					done       = (last_q == mrsp_pkg::EV_UNREAD);
					last_d     = mrsp_pkg::EV_OK;
				end
			end
			RS_U: if (rx_byte == mrsp_pkg::CH_N) state_d = RS_UN;
			RS_UN: if (rx_byte == mrsp_pkg::CH_R) state_d = RS_UNR;
			RS_UNR: if (rx_byte == mrsp_pkg::CH_E) state_d = RS_UNRE;
			RS_UNRE: if (rx_byte == mrsp_pkg::CH_A) state_d = RS_UNREA;
			RS_UNREA: begin
				if (rx_byte == mrsp_pkg::CH_D) begin
					resp_event = mrsp_pkg::EV_UNREAD;
					last_d     = mrsp_pkg::EV_UNREAD;
				end
			end
			default: state_d = RS_IDLE;
		endcase
	end

	assign stat.last_unread = (last_q == mrsp_pkg::EV_UNREAD);
	assign stat.unread_seen = (resp_event == mrsp_pkg::EV_UNREAD);

	// State advances once per accepted word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= RS_IDLE;
			last_q  <= mrsp_pkg::EV_NONE;
		end else if (step) begin
			state_q <= state_d;
			last_q  <= last_d;
		end
	end

endmodule

>>> hdl/mrsp_text.sv
// Message text capture between two '@' markers after an UNREAD reply.
// Depends on mrsp_pkg.
module mrsp_text #(
	parameter int TEXT_CAP = 64,
	localparam int TW = $clog2(TEXT_CAP)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [7:0]            rx_byte,
	input  mrsp_pkg::reply_stat_t stat,
	output logic                  wr,
	output logic [TW-1:0]         index,
	output logic [TW-1:0]         length
);

	localparam logic [TW-1:0] LAST_SLOT = TW'(TEXT_CAP - 1);

	logic          inside_q, inside_d;
	logic [TW-1:0] pos_q, pos_d, pos_a;

	// Store first, then handle markers, then the UNREAD reset.
	always_comb begin
		wr       = stat.last_unread && inside_q && (pos_q < LAST_SLOT);
		index    = wr ? pos_q : '0;
		pos_a    = wr ? pos_q + TW'(1) : pos_q;
		pos_d    = pos_a;
		inside_d = inside_q;
		if (rx_byte == mrsp_pkg::CH_AT) begin
			if (!inside_q) begin
				inside_d = 1'b1;
				pos_d    = '0;
			end else begin
				// The closing marker was stored; take it back out.
				pos_d    = (pos_a != '0) ? pos_a - TW'(1) : '0;
				inside_d = 1'b0;
			end
		end
		if (stat.unread_seen) begin
			pos_d    = '0;
			inside_d = 1'b0;
		end
	end

	assign length = pos_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q <= 1'b0;
			pos_q    <= '0;
		end else if (step) begin
			inside_q <= inside_d;
			pos_q    <= pos_d;
		end
	end

endmodule

>>> hdl/mrsp_number.sv
// Phone number capture: a quote, a plus, then digits up to the buffer capacity.
// Depends on mrsp_pkg.
module mrsp_number #(
	parameter int NUMBER_CAP = 32,
	localparam int NW = $clog2(NUMBER_CAP)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  logic [7:0]    rx_byte,
	output logic          wr,
	output logic [NW-1:0] index,
	output logic [NW-1:0] length
);

	typedef enum logic [1:0] {
		NS_IDLE  = 2'd0,
		NS_QUOTE = 2'd1,
		NS_DIGIT = 2'd2
	} nstate_t;

	localparam logic [NW-1:0] LAST_SLOT = NW'(NUMBER_CAP - 1);

	nstate_t       state_q, state_d;
	logic [NW-1:0] pos_q, pos_d, len_q, len_d;
	logic          is_digit;

	assign is_digit = (rx_byte >= mrsp_pkg::CH_DIG0) && (rx_byte <= mrsp_pkg::CH_DIG9);

	// Next number state, position and length.
	always_comb begin
		state_d = state_q;
		pos_d   = pos_q;
		len_d   = len_q;
		wr      = 1'b0;
		index   = '0;
		case (state_q)
			NS_IDLE: begin
				if (rx_byte == mrsp_pkg::CH_QUOTE) begin
					state_d = NS_QUOTE;
					pos_d   = '0;
				end
			end
			NS_QUOTE: begin
				if (rx_byte == mrsp_pkg::CH_PLUS) begin
					wr      = 1'b1;
					index   = pos_q;
					pos_d   = pos_q + NW'(1);
					len_d   = pos_q + NW'(1);
					state_d = NS_DIGIT;
				end else begin
					state_d = NS_IDLE;
					pos_d   = '0;
				end
			end
			NS_DIGIT: begin
				if (is_digit) begin
					if (pos_q < LAST_SLOT) begin
						wr    = 1'b1;
						index = pos_q;
						pos_d = pos_q + NW'(1);
					end
					len_d = pos_d;
				end else if (rx_byte == mrsp_pkg::CH_QUOTE) begin
					// Closing quote keeps the captured number.
					pos_d   = '0;
					state_d = NS_IDLE;
				end else begin
					len_d   = '0;
					pos_d   = '0;
					state_d = NS_IDLE;
				end
			end
			default: begin
				len_d   = '0;
				pos_d   = '0;
				state_d = NS_IDLE;
			end
		endcase
	end

	assign length = len_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= NS_IDLE;
			pos_q   <= '0;
			len_q   <= '0;
		end else if (step) begin
			state_q <= state_d;
			pos_q   <= pos_d;
			len_q   <= len_d;
		end
	end

endmodule

>>> hdl/modem_response_sms_parser.sv
// Modem response and SMS parser: top level with input and result registers.
// Depends on mrsp_pkg, mrsp_reply, mrsp_text and mrsp_number.
//
// One received byte is taken per clock cycle while result words are being taken. Each byte
// enters an input register, passes combinationally through the reply recognizer, the text
// capture and the number capture, and lands in the result register. A result word is
// presented once its byte has moved on into the result register; that move waits while the
// result register is full and not being emptied. The per-byte state updates of the three
// recognizers are made with that move, which sets the rate at one byte per cycle. The message
// and number buffers are outside the block: it reports write strobes, positions and
// string lengths. Positions are TEXT_CAP and NUMBER_CAP wide in log2 bits; one slot
// of each buffer is kept free for a terminator.
module modem_response_sms_parser #(
	parameter int TEXT_CAP   = 64,
	parameter int NUMBER_CAP = 32,
	localparam int TW = $clog2(TEXT_CAP),
	localparam int NW = $clog2(NUMBER_CAP)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          byte_valid,
	output logic          byte_ready,
	input  logic [7:0]    rx_byte,
	output logic          result_valid,
	input  logic          result_ready,
	output logic [1:0]    response_event,
	output logic          message_complete,
	output logic          text_write,
	output logic [TW-1:0] text_index,
	output logic [TW-1:0] text_length,
	output logic          number_write,
	output logic [NW-1:0] number_index,
	output logic [NW-1:0] number_length
);

	logic                  valid_s1;
	logic [7:0]            byte_s1;
	logic                  step;
	mrsp_pkg::event_t      ev;
	logic                  done;
	mrsp_pkg::reply_stat_t stat;
	logic                  tw;
	logic [TW-1:0]         ti, tl;
	logic                  nw;
	logic [NW-1:0]         ni, nl;

	// The input word moves on when the result register is free or being emptied.
	assign step       = valid_s1 && (!result_valid || result_ready);
	assign byte_ready = !valid_s1 || step;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ready && byte_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	mrsp_reply u_reply (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.rx_byte    (byte_s1),
		.resp_event (ev),
		.done       (done),
		.stat       (stat)
	);

	mrsp_text #(.TEXT_CAP(TEXT_CAP)) u_text (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.rx_byte (byte_s1),
		.stat    (stat),
		.wr      (tw),
		.index   (ti),
		.length  (tl)
	);

	mrsp_number #(.NUMBER_CAP(NUMBER_CAP)) u_number (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.rx_byte (byte_s1),
		.wr      (nw),
		.index   (ni),
		.length  (nl)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (step) begin
			result_valid <= 1'b1;
		end else if (result_ready) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			response_event   <= ev;
			message_complete <= done;
			text_write       <= tw;
			text_index       <= ti;
			text_length      <= tl;
			number_write     <= nw;
			number_index     <= ni;
			number_length    <= nl;
		end
	end

endmodule

>>> verif/testbench.sv
// Self-checking testbench for the modem response and SMS parser.
// Depends on mrsp_pkg and modem_response_sms_parser from hdl/; the expected words come
// from a behavioral model of the parser kept inside this file.
`timescale 1ns / 100ps

module testbench;

	localparam int TEXT_CAP     = 64;
	localparam int NUMBER_CAP   = 32;
	localparam int RANDOM_BYTES = 2000;
	localparam int MAX_WAIT     = 13;
	localparam int SETTLE_CYCLES = 20;
	localparam int CYCLE_LIMIT  = 400000;

	// Phases of the reply recognizer and of the number capture.
	typedef enum logic [3:0] {
		RP_IDLE, RP_O, RP_GT, RP_OK, RP_OKCR, RP_U, RP_UN, RP_UNR, RP_UNRE, RP_UNREA
	} reply_phase_t;

	typedef enum logic [1:0] {
		NUM_IDLE, NUM_QUOTE, NUM_DIGITS
	} number_phase_t;

	// One result word as the parser reports it.
	typedef struct packed {
		mrsp_pkg::event_t evt;
		logic       done;
		logic       text_write;
		logic [5:0] text_index;
		logic [5:0] text_length;
		logic       number_write;
		logic [4:0] number_index;
		logic [4:0] number_length;
	} parse_word_t;

	// One byte waiting to be sent; drain_first holds it back until all results are in.
	typedef struct {
		logic [7:0] data;
		bit         drain_first;
	} rx_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        byte_valid = 1'b0;
	logic        byte_ready;
	logic [7:0]  rx_byte = 8'h00;
	logic        result_valid;
	logic        result_ready = 1'b0;
	logic [1:0]  response_event;
	logic        message_complete;
	logic        text_write;
	logic [5:0]  text_index;
	logic [5:0]  text_length;
	logic        number_write;
	logic [4:0]  number_index;
	logic [4:0]  number_length;

	rx_item_t    pending_bytes[$];
	parse_word_t parsed_words[$];
	rx_item_t    next_item;
	parse_word_t oldest_word;
	bit          drain_next = 1'b0;
	int          bytes_issued = 0;
	int          bytes_taken = 0;
	int          results_taken = 0;
	int          results_seen = 0;
	int          send_wait = 0;
	int          recv_wait = 0;
	bit          send_idling = 1'b1;
	bit          recv_idling = 1'b1;
	int          mismatches = 0;
	int          cycle_count = 0;

	// Parser state as predicted from the accepted bytes.
	reply_phase_t     reply_phase = RP_IDLE;
	number_phase_t    number_phase = NUM_IDLE;
	mrsp_pkg::event_t last_reply = mrsp_pkg::EV_NONE;
	bit               in_text = 1'b0;
	int               text_pos = 0;
	int               number_pos = 0;
	int               number_len = 0;

	modem_response_sms_parser #(
		.TEXT_CAP(TEXT_CAP),
		.NUMBER_CAP(NUMBER_CAP)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_ready(byte_ready),
		.rx_byte(rx_byte),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.response_event(response_event),
		.message_complete(message_complete),
		.text_write(text_write),
		.text_index(text_index),
		.text_length(text_length),
		.number_write(number_write),
		.number_index(number_index),
		.number_length(number_length)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Advance the predicted parser state by one byte and return the word it reports.
	function automatic parse_word_t parse_byte(input logic [7:0] b);
		parse_word_t w;
		w = '0;

		// The text is stored before the marker check, so a closing marker is stored too.
		if (last_reply == mrsp_pkg::EV_UNREAD && in_text && text_pos < TEXT_CAP - 1) begin
			w.text_write = 1'b1;
			w.text_index = text_pos[5:0];
			text_pos++;
		end
		if (b == mrsp_pkg::CH_AT) begin
			if (!in_text) begin
				in_text = 1'b1;
				text_pos = 0;
			end else begin
				if (text_pos > 0)
					text_pos--;
				in_text = 1'b0;
			end
		end

		// A mismatching byte sends the recognizer to idle without a retry.
		case (reply_phase)
			RP_IDLE: begin
				if (b == mrsp_pkg::CH_O)
					reply_phase = RP_O;
				else if (b == mrsp_pkg::CH_GT)
					reply_phase = RP_GT;
				else if (b == mrsp_pkg::CH_U)
					reply_phase = RP_U;
			end
			RP_O:    reply_phase = (b == mrsp_pkg::CH_K) ? RP_OK : RP_IDLE;
			RP_OK:   reply_phase = (b == mrsp_pkg::CH_CR) ? RP_OKCR : RP_IDLE;
			RP_U:    reply_phase = (b == mrsp_pkg::CH_N) ? RP_UN : RP_IDLE;
			RP_UN:   reply_phase = (b == mrsp_pkg::CH_R) ? RP_UNR : RP_IDLE;
			RP_UNR:  reply_phase = (b == mrsp_pkg::CH_E) ? RP_UNRE : RP_IDLE;
			RP_UNRE: reply_phase = (b == mrsp_pkg::CH_A) ? RP_UNREA : RP_IDLE;
			RP_GT: begin
				if (b == mrsp_pkg::CH_SPACE) begin
					w.evt = mrsp_pkg::EV_PROMPT;
					last_reply = mrsp_pkg::EV_PROMPT;
				end
				reply_phase = RP_IDLE;
			end
			RP_OKCR: begin
				if (b == mrsp_pkg::CH_LF) begin
					w.evt = mrsp_pkg::EV_OK;
					w.done = (last_reply == mrsp_pkg::EV_UNREAD);
					last_reply = mrsp_pkg::EV_OK;
				end
				reply_phase = RP_IDLE;
			end
			RP_UNREA: begin
				if (b == mrsp_pkg::CH_D) begin
					w.evt = mrsp_pkg::EV_UNREAD;
					last_reply = mrsp_pkg::EV_UNREAD;
					text_pos = 0;
					in_text = 1'b0;
				end
				reply_phase = RP_IDLE;
			end
			default: reply_phase = RP_IDLE;
		endcase

		// Phone number: quote, plus, then digits up to the capacity.
		case (number_phase)
			NUM_IDLE: begin
				if (b == mrsp_pkg::CH_QUOTE) begin
					number_phase = NUM_QUOTE;
					number_pos = 0;
				end
			end
			NUM_QUOTE: begin
				if (b == mrsp_pkg::CH_PLUS) begin
					w.number_write = 1'b1;
					w.number_index = number_pos[4:0];
					number_pos++;
					number_len = number_pos;
					number_phase = NUM_DIGITS;
				end else begin
					number_phase = NUM_IDLE;
					number_pos = 0;
				end
			end
			NUM_DIGITS: begin
				if (b >= mrsp_pkg::CH_DIG0 && b <= mrsp_pkg::CH_DIG9) begin
					if (number_pos < NUMBER_CAP - 1) begin
						w.number_write = 1'b1;
						w.number_index = number_pos[4:0];
						number_pos++;
					end
					number_len = number_pos;
				end else begin
					// A closing quote keeps the number, anything else clears it.
					if (b != mrsp_pkg::CH_QUOTE)
						number_len = 0;
					number_pos = 0;
					number_phase = NUM_IDLE;
				end
			end
			default: begin
				number_len = 0;
				number_pos = 0;
				number_phase = NUM_IDLE;
			end
		endcase

		w.text_length = text_pos[5:0];
		w.number_length = number_len[4:0];
		return w;
	endfunction

	function automatic void check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	task automatic push_byte(input logic [7:0] b);
		rx_item_t item;
		item.data = b;
		item.drain_first = drain_next;
		drain_next = 1'b0;
		pending_bytes.push_back(item);
	endtask

	task automatic push_chars(input string s);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i]);
	endtask

	task automatic push_ok_reply();
		push_chars("OK");
		push_byte(mrsp_pkg::CH_CR);
		push_byte(mrsp_pkg::CH_LF);
	endtask

	// One random sequence: mostly well-formed replies and captures, some broken ones, some noise.
	task automatic add_sequence();
		int         kind;
		int         n;
		string      word;
		logic [7:0] c;
		kind = $urandom_range(0, 99);
		if (kind < 30) begin
			// Unread message with marked text, sometimes long enough to fill the buffer.
			push_chars("UNREAD");
			if ($urandom_range(0, 3) == 0)
				push_chars(",\"+33\",");
			push_byte(mrsp_pkg::CH_AT);
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(55, 75) : $urandom_range(0, 12);
			for (int i = 0; i < n; i++) begin
				c = 8'($urandom_range(32, 126));
				push_byte((c == mrsp_pkg::CH_AT) ? mrsp_pkg::CH_SPACE : c);
			end
			if ($urandom_range(0, 7) != 0)
				push_byte(mrsp_pkg::CH_AT);
			if ($urandom_range(0, 3) != 0)
				push_ok_reply();
		end else if (kind < 50) begin
			// Phone number, sometimes past its capacity, ended by a quote or another byte.
			push_byte(mrsp_pkg::CH_QUOTE);
			if ($urandom_range(0, 7) != 0)
				push_byte(mrsp_pkg::CH_PLUS);
			n = ($urandom_range(0, 7) == 0) ? $urandom_range(28, 36) : $urandom_range(0, 12);
			for (int i = 0; i < n; i++)
				push_byte(8'(mrsp_pkg::CH_DIG0 + $urandom_range(0, 9)));
			push_byte(($urandom_range(0, 3) != 0) ?
				mrsp_pkg::CH_QUOTE : 8'($urandom_range(0, 255)));
		end else if (kind < 62) begin
			push_ok_reply();
		end else if (kind < 70) begin
			push_byte(mrsp_pkg::CH_GT);
			push_byte(($urandom_range(0, 3) != 0) ?
				mrsp_pkg::CH_SPACE : 8'($urandom_range(0, 255)));
		end else if (kind < 85) begin
			// A reply cut short by a random byte.
			if ($urandom_range(0, 1) == 0) begin
				word = "UNREAD";
				n = $urandom_range(1, 5);
				for (int i = 0; i < n; i++)
					push_byte(word[i]);
			end else begin
				push_byte(mrsp_pkg::CH_O);
				if ($urandom_range(0, 1) == 0)
					push_byte(mrsp_pkg::CH_K);
				if ($urandom_range(0, 1) == 0)
					push_byte(mrsp_pkg::CH_CR);
			end
			push_byte(8'($urandom_range(0, 255)));
		end else begin
			n = $urandom_range(1, 4);
			for (int i = 0; i < n; i++)
				push_byte(8'($urandom_range(0, 255)));
		end
	endtask

	// Stimulus, reset and end of run.
	initial begin
		int directed_count;
		int seq_count;
		push_byte(8'h00);
		push_byte(8'hFF);
		// A closing marker with no text must not step the position below zero.
		push_chars("@@");
		// A broken prompt does not retry its byte as a new start.
		push_chars(">O");
		push_chars("> ");
		push_chars("UNREAD@h@");
		push_ok_reply();
		push_chars("\"+12\"");
		push_chars("\"+1x");
		directed_count = pending_bytes.size();

		seq_count = 0;
		while (pending_bytes.size() < directed_count + RANDOM_BYTES) begin
			if (seq_count % 150 == 0)
				drain_next = 1'b1;
			add_sequence();
			seq_count++;
		end

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		while (pending_bytes.size() != 0 || bytes_taken != bytes_issued ||
				parsed_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatches == 0 && parsed_words.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// Byte driver: new words go out at the falling edge after a random gap.
	always @(negedge clk) begin
		if (arst_n && (!byte_valid || bytes_taken == bytes_issued)) begin
			if (send_wait > 0) begin
				byte_valid <= 1'b0;
				send_wait--;
			end else if (pending_bytes.size() == 0 ||
					(pending_bytes[0].drain_first && parsed_words.size() != 0)) begin
				byte_valid <= 1'b0;
			end else begin
				next_item = pending_bytes.pop_front();
				rx_byte <= next_item.data;
				byte_valid <= 1'b1;
				bytes_issued++;
				if ($urandom_range(0, 63) == 0)
					send_idling = !send_idling;
				send_wait = send_idling ? $urandom_range(0, MAX_WAIT) : 0;
			end
		end
	end

	// Result receiver: after each accepted word, ready drops for a random stall.
	always @(negedge clk) begin
		if (arst_n) begin
			if (results_taken != results_seen) begin
				results_seen = results_taken;
				if ($urandom_range(0, 63) == 0)
					recv_idling = !recv_idling;
				recv_wait = recv_idling ? $urandom_range(0, MAX_WAIT) : 0;
			end
			if (recv_wait > 0) begin
				result_ready <= 1'b0;
				recv_wait--;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	// Monitor: predict on each accepted byte, compare each accepted result word.
	always @(posedge clk) begin
		if (arst_n) begin
			if (byte_valid && byte_ready) begin
				parsed_words.push_back(parse_byte(rx_byte));
				bytes_taken++;
			end
			if (result_valid && result_ready) begin
				results_taken++;
				if (parsed_words.size() == 0) begin
					$error("result word with no byte to account for it");
					mismatches++;
				end else begin
					oldest_word = parsed_words.pop_front();
					check_field("response_event", oldest_word.evt, response_event);
					check_field("message_complete", oldest_word.done, message_complete);
					check_field("text_write", oldest_word.text_write, text_write);
					check_field("text_index", oldest_word.text_index, text_index);
					check_field("text_length", oldest_word.text_length, text_length);
					check_field("number_write", oldest_word.number_write, number_write);
					check_field("number_index", oldest_word.number_index, number_index);
					check_field("number_length", oldest_word.number_length, number_length);
				end
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

endmodule
